// File: sv/cpnt_pkg.sv
// Shared types and constants for the channel pedestal and noise tracker.
// No dependencies; imported by the divider, square-root and top modules.
package cpnt_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV_MEAN,
      ST_MUL,
      ST_UPDATE,
      ST_DIV_VAR,
      ST_SQRT,
      ST_EMIT
   } state_type;

   typedef logic [6:0] step_type;

   typedef struct packed {
      logic     start;
      step_type steps;
   } div_cmd_type;

   localparam int COUNT_W = 32;
   localparam int MEAN_W  = 22;
   localparam int SUM_W   = 64;
   localparam int RMS_W   = 16;
   localparam int MEM_W   = COUNT_W + MEAN_W + SUM_W;

   // rounded mean dividend is at most 33 bits wide, left-aligned in the divider
   localparam step_type MEAN_DIV_STEPS = 7'd33;
   localparam step_type VAR_DIV_STEPS  = 7'd64;
   localparam logic [4:0] SQRT_STEPS   = 5'd16;

endpackage

// File: sv/cpnt_divider.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Depends on cpnt_pkg for the command struct.
module cpnt_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cpnt_pkg::div_cmd_type cmd,
   input  logic [63:0]           dividend,
   input  logic [31:0]           divisor,
   output logic                  done,
   output logic [63:0]           quotient
);
   import cpnt_pkg::*;

   logic [63:0] num_ff;
   logic [63:0] quo_ff;
   logic [31:0] rem_ff;
   logic [31:0] div_ff;
   step_type    left_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;
   logic [31:0] rem_in;

   always_comb begin
      trial  = {rem_ff, num_ff[63]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? diff[31:0] : trial[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && left_ff == 7'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff  <= dividend;
         div_ff  <= divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
         left_ff <= cmd.steps;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[62:0], 1'b0};
         rem_ff  <= rem_in;
         quo_ff  <= {quo_ff[62:0], fits};
         left_ff <= left_ff - 7'd1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/cpnt_isqrt.sv
// Digit-by-digit integer square root of a 32-bit value, one root bit per cycle.
// Depends on cpnt_pkg for the step count.
module cpnt_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        done,
   output logic [15:0] root
);
   import cpnt_pkg::*;

   logic [31:0] rad_ff;
   logic [17:0] rem_ff;
   logic [15:0] root_ff;
   logic [4:0]  left_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [19:0] cur;
   logic [19:0] trial;
   logic [19:0] diff;
   logic        fits;

   always_comb begin
      cur   = {rem_ff, rad_ff[31:30]};
      trial = {2'b00, root_ff, 2'b01};
      diff  = cur - trial;
      fits  = cur >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && left_ff == 5'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         left_ff <= SQRT_STEPS;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[29:0], 2'b00};
         rem_ff  <= fits ? diff[17:0] : cur[17:0];
         root_ff <= {root_ff[14:0], fits};
         left_ff <= left_ff - 5'd1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: sv/channel_pedestal_noise_tracker_top.sv
// Pedestal and noise tracker: per-channel Welford mean and variance with rms output.
// Depends on cpnt_pkg, cpnt_divider and cpnt_isqrt.
//
// One ADC sample is taken at a time and the block stalls its input until the
// sample is fully processed. A sample that is not the last of a hit passes the
// read, load, 33-step rounded mean division, multiply and update steps before the
// next transfer; the last sample of a hit adds a 64-step division of the sum by
// the count and a 16-step square root (skipped when the variance overflows), all
// on one bit-serial divider and one root unit. An out-of-range address goes
// straight to the emit step and is answered with bad_address set. After reset the
// state memory is zeroed one entry per cycle, and no sample is accepted during
// that sweep. Results wait in an output register, so the next sample is taken
// while a result is stalled; a further result then waits in the emit step, with
// the input stalled, until that register drains.
module channel_pedestal_noise_tracker_top #(
   parameter int LINK_COUNT    = 24,
   parameter int BOARD_COUNT   = 40,
   parameter int CHANNEL_COUNT = 64,
   parameter int SAMPLE_BITS   = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_link,
   input  logic [5:0]  req_board,
   input  logic [5:0]  req_channel,
   input  logic [9:0]  req_sample,
   input  logic        req_last_of_hit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [21:0] rsp_pedestal_out,
   output logic [15:0] rsp_rms_out,
   output logic        rsp_bad_address
);
   import cpnt_pkg::*;

   localparam int STORE_DEPTH = LINK_COUNT * BOARD_COUNT * CHANNEL_COUNT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int MEAN_FRAC   = MEAN_W - SAMPLE_BITS;
   localparam int RMS_FRAC    = RMS_W - SAMPLE_BITS;
   localparam int VAR_SHIFT   = 2 * (MEAN_FRAC - RMS_FRAC);
   localparam logic [31:0] SAMPLE_MASK = (32'd1 << SAMPLE_BITS) - 32'd1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   state_type state_ff, state_in;

   logic [MEM_W-1:0] mem [STORE_DEPTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] wr_data;
   logic [ADDR_W-1:0] wr_addr;

   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [MEAN_W-1:0] x_ff;
   logic              last_ff;
   logic              bad_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [MEAN_W-1:0]  mean_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [MEAN_W-1:0]  dmag_ff;
   logic               up_ff;
   logic [43:0]        prod_ff;
   logic [RMS_W-1:0]   rms_ff;

   logic              rsp_valid_ff;
   logic [21:0]       rsp_pedestal_ff;
   logic [15:0]       rsp_rms_ff;
   logic              rsp_bad_ff;

   // control decode
   logic        accept;
   logic        out_free;
   logic        mem_we;
   logic        sqrt_start;
   div_cmd_type div_cmd;
   logic        div_done;
   logic [63:0] div_quo;
   logic        sqrt_done;
   logic [15:0] sqrt_root;

   // datapath terms
   logic              addr_bad;
   logic [ADDR_W-1:0] addr_in;
   logic [MEAN_W-1:0] x_in;
   logic [COUNT_W-1:0] old_cnt, cnt_in;
   logic [MEAN_W-1:0]  old_mean;
   logic [SUM_W-1:0]   old_sum;
   logic               up_in;
   logic [MEAN_W-1:0]  dmag_in;
   logic [32:0]        mean_dividend;
   logic [63:0]        div_dividend;
   logic [31:0]        div_divisor;
   logic [MEAN_W-1:0]  m1;
   logic [MEAN_W-1:0]  emag;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_new;
   logic [63:0]        var_full;
   logic               var_over;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      addr_bad = (32'(req_link) >= LINK_COUNT) || (32'(req_board) >= BOARD_COUNT)
                 || (32'(req_channel) >= CHANNEL_COUNT);
      addr_in  = ADDR_W'((32'(req_link) * BOARD_COUNT + 32'(req_board)) * CHANNEL_COUNT
                 + 32'(req_channel));
      x_in     = MEAN_W'((32'(req_sample) & SAMPLE_MASK) << MEAN_FRAC);

      {old_cnt, old_mean, old_sum} = rd_data_ff;
      cnt_in  = (old_cnt == '1) ? old_cnt : old_cnt + 32'd1;
      up_in   = x_ff >= old_mean;
      dmag_in = up_in ? x_ff - old_mean : old_mean - x_ff;
      mean_dividend = {11'd0, dmag_in} + {2'b00, cnt_in[31:1]};

      m1   = up_ff ? mean_ff + div_quo[MEAN_W-1:0] : mean_ff - div_quo[MEAN_W-1:0];
      emag = up_ff ? x_ff - mean_ff : mean_ff - x_ff;

      sum_wide = {1'b0, sum_ff} + {21'd0, prod_ff};
      sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

      var_full = div_quo >> VAR_SHIFT;
      var_over = |var_full[63:32];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:     if (accept) state_in = addr_bad ? ST_EMIT : ST_READ;
         ST_READ:     state_in = ST_LOAD;
         ST_LOAD:     state_in = ST_DIV_MEAN;
         ST_DIV_MEAN: if (div_done) state_in = ST_MUL;
         ST_MUL:      state_in = ST_UPDATE;
         ST_UPDATE:   state_in = last_ff ? ST_DIV_VAR : ST_IDLE;
         ST_DIV_VAR:  if (div_done) state_in = var_over ? ST_EMIT : ST_SQRT;
         ST_SQRT:     if (sqrt_done) state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall     = 1'b1;
      mem_we        = 1'b0;
      sqrt_start    = 1'b0;
      div_cmd.start = 1'b0;
      div_cmd.steps = MEAN_DIV_STEPS;
      div_dividend  = {mean_dividend, 31'd0};
      div_divisor   = cnt_in;
      wr_addr       = addr_ff;
      wr_data       = {cnt_ff, m1, sum_new};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE:  req_stall = 1'b0;
         ST_LOAD:  div_cmd.start = 1'b1;
         ST_UPDATE: begin
            mem_we        = 1'b1;
            wr_data       = {cnt_ff, mean_ff, sum_new};
            div_cmd.start = last_ff;
            div_cmd.steps = VAR_DIV_STEPS;
            div_dividend  = sum_new;
            div_divisor   = cnt_ff;
         end
         ST_DIV_VAR: sqrt_start = div_done && !var_over;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= addr_bad ? '0 : addr_in;
         x_ff    <= x_in;
         last_ff <= req_last_of_hit;
         bad_ff  <= addr_bad;
      end
      if (state_ff == ST_LOAD) begin
         cnt_ff  <= cnt_in;
         mean_ff <= old_mean;
         sum_ff  <= old_sum;
         dmag_ff <= dmag_in;
         up_ff   <= up_in;
      end
      if (state_ff == ST_DIV_MEAN && div_done) begin
         mean_ff <= m1;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= 44'(dmag_ff) * 44'(emag);
      end
      if (state_ff == ST_UPDATE) begin
         sum_ff <= sum_new;
      end
      if (state_ff == ST_DIV_VAR && div_done) begin
         rms_ff <= '1;
      end
      if (state_ff == ST_SQRT && sqrt_done) begin
         rms_ff <= sqrt_root;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_pedestal_ff <= bad_ff ? '0 : mean_ff;
         rsp_rms_ff      <= bad_ff ? '0 : rms_ff;
         rsp_bad_ff      <= bad_ff;
      end
   end

   cpnt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   cpnt_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (var_full[31:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pedestal_out = rsp_pedestal_ff;
   assign rsp_rms_out      = rsp_rms_ff;
   assign rsp_bad_address  = rsp_bad_ff;

`ifndef ASSERT_OFF
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit state");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_pedestal_ff == '0 && rsp_rms_ff == '0)
      else $error("bad address result carries nonzero payload");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_MEAN || state_ff == ST_DIV_VAR)
      else $error("divider finished outside a division state");

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall && !rsp_valid_ff)
      else $error("activity during memory clear");
`endif

endmodule

// File: tb/sv/cpnt_checker.sv
// Checker for the channel pedestal and noise tracker: watches both channels,
// predicts each result with its own per-channel mean/variance store, compares.
// Depends on the port widths and default parameters of channel_pedestal_noise_tracker_top.
module cpnt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [4:0]  req_link,
   input  logic [5:0]  req_board,
   input  logic [5:0]  req_channel,
   input  logic [9:0]  req_sample,
   input  logic        req_last_of_hit,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [21:0] rsp_pedestal_out,
   input  logic [15:0] rsp_rms_out,
   input  logic        rsp_bad_address,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          bad_checked_count
);

   localparam int LINKS     = 24;
   localparam int BOARDS    = 40;
   localparam int CHANNELS  = 64;
   localparam int MEAN_FRAC = 12;
   localparam int VAR_SHIFT = 12;

   typedef struct {
      logic [21:0] pedestal;
      logic [15:0] rms;
      logic        bad_address;
   } channel_stats_type;

   channel_stats_type expected_stats[$];

   // per-channel store; entries never written read as zero
   int unsigned       sample_total[int];
   logic [21:0]       mean_store[int];
   longint unsigned   deviation_sum[int];

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, rem, bitv;
      root = 0;
      rem  = v;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   task automatic track_sample(input logic [4:0] lk, input logic [5:0] bd,
                               input logic [5:0] ch, input logic [9:0] smp,
                               input logic last);
      channel_stats_type res;
      int                addr;
      int unsigned       cnt;
      longint unsigned   n, x, m0, m1, dmag, emag, prod, sum, variance, root;
      if (lk >= LINKS || bd >= BOARDS || ch >= CHANNELS) begin
         res.pedestal    = '0;
         res.rms         = '0;
         res.bad_address = 1'b1;
         expected_stats.push_back(res);
         return;
      end
      addr = (int'(lk) * BOARDS + int'(bd)) * CHANNELS + int'(ch);
      cnt  = sample_total.exists(addr) ? sample_total[addr] : 0;
      m0   = mean_store.exists(addr) ? 64'(mean_store[addr]) : 0;
      sum  = deviation_sum.exists(addr) ? deviation_sum[addr] : 0;
      if (cnt != 32'hFFFF_FFFF) cnt++;
      sample_total[addr] = cnt;
      n = 64'(cnt);
      x = 64'(smp) << MEAN_FRAC;
      if (x >= m0) begin
         dmag = x - m0;
         m1   = m0 + (dmag + n / 2) / n;
         emag = x - m1;
      end else begin
         dmag = m0 - x;
         m1   = m0 - (dmag + n / 2) / n;
         emag = m1 - x;
      end
      mean_store[addr] = m1[21:0];
      prod = dmag * emag;
      // saturate the sum at its top value
      if (sum > 64'hFFFF_FFFF_FFFF_FFFF - prod) sum = 64'hFFFF_FFFF_FFFF_FFFF;
      else sum += prod;
      deviation_sum[addr] = sum;
      if (!last) return;
      variance = (sum / n) >> VAR_SHIFT;
      if (variance >= 64'h1_0000_0000) root = 64'hFFFF;
      else root = int_sqrt(variance);
      if (root > 64'hFFFF) root = 64'hFFFF;
      res.pedestal    = m1[21:0];
      res.rms         = root[15:0];
      res.bad_address = 1'b0;
      expected_stats.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input channel_stats_type want);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch (%s): expected ped=%h rms=%h bad=%b, got ped=%h rms=%h bad=%b",
                  what, want.pedestal, want.rms, want.bad_address,
                  rsp_pedestal_out, rsp_rms_out, rsp_bad_address);
   endtask

   always @(posedge clock) begin
      channel_stats_type want;
      if (reset) begin
         fail_count        <= 0;
         checked_count     <= 0;
         bad_checked_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               want = '{pedestal: '0, rms: '0, bad_address: 1'b0};
               report_mismatch("unexpected transfer", want);
            end else begin
               want = expected_stats.pop_front();
               checked_count++;
               if (want.bad_address) bad_checked_count++;
               if (rsp_pedestal_out !== want.pedestal || rsp_rms_out !== want.rms ||
                   rsp_bad_address !== want.bad_address)
                  report_mismatch("field", want);
            end
         end
         if (req_valid && !req_stall)
            track_sample(req_link, req_board, req_channel, req_sample, req_last_of_hit);
      end
      pending_count = expected_stats.size();
   end

endmodule

// File: tb/sv/channel_pedestal_noise_tracker_top_tb.sv
// Testbench top for the channel pedestal and noise tracker: clock, reset,
// sample stimulus and result-side stalls. Depends on the block and cpnt_checker.
module channel_pedestal_noise_tracker_top_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_link;
   logic [5:0]  req_board;
   logic [5:0]  req_channel;
   logic [9:0]  req_sample;
   logic        req_last_of_hit;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [21:0] rsp_pedestal_out;
   logic [15:0] rsp_rms_out;
   logic        rsp_bad_address;

   int fail_count, pending_count, checked_count, bad_checked_count;
   int sent_count;
   bit no_idle;
   bit hold_rsp;

   channel_pedestal_noise_tracker_top uut (.*);

   cpnt_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(25_000_000);
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_sample(input logic [4:0] lk, input logic [5:0] bd,
                              input logic [5:0] ch, input logic [9:0] smp,
                              input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_link        = lk;
      req_board       = bd;
      req_channel     = ch;
      req_sample      = smp;
      req_last_of_hit = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int gap;
      bit held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            held = 1'b1;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
               rsp_stall = 1'b1;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [4:0] hot_link[8];
      logic [5:0] hot_board[8];
      logic [5:0] hot_chan[8];
      int         hot_ped[8];
      int         hot_noise[8];
      int         hit_left[8];
      int         k, pick, value, wait_cycles;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_link        = '0;
      req_board       = '0;
      req_channel     = '0;
      req_sample      = '0;
      req_last_of_hit = 1'b0;
      no_idle         = 1'b0;
      hold_rsp        = 1'b0;
      sent_count      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners of the address space and sample range
      send_sample(5'd0, 6'd0, 6'd0, 10'd0, 1'b1);
      send_sample(5'd0, 6'd0, 6'd0, 10'd1023, 1'b1);
      send_sample(5'd0, 6'd0, 6'd0, 10'd512, 1'b0);
      send_sample(5'd0, 6'd0, 6'd0, 10'd0, 1'b1);
      send_sample(5'd23, 6'd39, 6'd63, 10'd1023, 1'b1);
      send_sample(5'd23, 6'd39, 6'd63, 10'd1023, 1'b1);
      send_sample(5'd23, 6'd39, 6'd63, 10'd0, 1'b0);
      send_sample(5'd23, 6'd39, 6'd63, 10'd1, 1'b1);
      send_sample(5'd12, 6'd21, 6'd42, 10'd341, 1'b0);
      send_sample(5'd12, 6'd21, 6'd42, 10'd682, 1'b1);
      // out-of-range link or board answers with the flag, last or not
      send_sample(5'd24, 6'd0, 6'd0, 10'd100, 1'b0);
      send_sample(5'd31, 6'd63, 6'd63, 10'd1023, 1'b1);
      send_sample(5'd0, 6'd40, 6'd5, 10'd7, 1'b0);
      send_sample(5'd5, 6'd63, 6'd0, 10'd7, 1'b1);
      // valid samples without the last flag give nothing; the last one gives the result
      send_sample(5'd3, 6'd3, 6'd3, 10'd300, 1'b0);
      send_sample(5'd3, 6'd3, 6'd3, 10'd301, 1'b0);
      send_sample(5'd3, 6'd3, 6'd3, 10'd299, 1'b1);

      for (k = 0; k < 8; k++) begin
         hot_link[k]  = 5'($urandom_range(0, 23));
         hot_board[k] = 6'($urandom_range(0, 39));
         hot_chan[k]  = 6'($urandom_range(0, 63));
         hot_ped[k]   = $urandom_range(0, 1023);
         hot_noise[k] = (k == 0) ? 0 : $urandom_range(1, 1 << (k + 1));
         hit_left[k]  = $urandom_range(1, 6);
      end

      for (k = 0; k < 1900; k++) begin
         if (k == 300) hold_rsp = 1'b1;
         no_idle = (k >= 700 && k < 850);
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            pick  = $urandom_range(0, 7);
            value = hot_ped[pick] + $urandom_range(0, 2 * hot_noise[pick]) - hot_noise[pick];
            if ($urandom_range(0, 30) == 0) value = $urandom_range(0, 1) ? 1023 : 0;
            if (value < 0) value = 0;
            if (value > 1023) value = 1023;
            hit_left[pick]--;
            send_sample(hot_link[pick], hot_board[pick], hot_chan[pick], 10'(value),
                        hit_left[pick] == 0);
            if (hit_left[pick] == 0) hit_left[pick] = $urandom_range(1, 6);
         end else if (pick < 94) begin
            send_sample(5'($urandom_range(0, 23)), 6'($urandom_range(0, 39)),
                        6'($urandom_range(0, 63)), 10'($urandom),
                        1'($urandom_range(0, 1)));
         end else if (pick < 97) begin
            send_sample(5'($urandom_range(24, 31)), 6'($urandom), 6'($urandom),
                        10'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            send_sample(5'($urandom_range(0, 31)), 6'($urandom_range(40, 63)),
                        6'($urandom), 10'($urandom), 1'($urandom_range(0, 1)));
         end
      end
      req_valid = 1'b0;
      no_idle   = 1'b0;

      while (pending_count != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 300) begin
         @(posedge clock);
         wait_cycles++;
      end

      $display("sent %0d samples, checked %0d results (%0d with bad address)",
               sent_count, checked_count, bad_checked_count);
      $display("pedestal/rms tracked on hot channels, address corners and one long result hold-off");
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
